/* rtl/goc_pkg.sv */
// Shared types and constants of the graphlet orbit counter.
package goc_pkg;

    localparam int ID_W    = 10;
    localparam int OP_W    = 2;
    localparam int ORBITS  = 15;
    localparam int ORBIT_W = 4;
    localparam int TOTAL_W = 32;

    localparam logic [ORBIT_W-1:0] LAST_ORBIT = ORBIT_W'(ORBITS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_COUNT  = 2'd2
    } t_opcode;

endpackage

/* rtl/goc_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module goc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/goc_walker.sv */
// Sequencer that loads lists, clears the degree table and walks a query's neighbourhood.
module goc_walker #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 32,
    parameter int COUNT_WIDTH  = 32,
    localparam int VAW = $clog2(MAX_VERTICES),
    localparam int SW  = $clog2(MAX_DEGREE),
    localparam int DW  = $clog2(MAX_DEGREE + 1),
    localparam int AAW = VAW + SW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [goc_pkg::OP_W-1:0]     i_opcode,
    input  logic [goc_pkg::ID_W-1:0]     i_vertex_id,
    input  logic [goc_pkg::ID_W-1:0]     i_neighbor_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [goc_pkg::ORBIT_W-1:0]  o_orbit_index,
    output logic [goc_pkg::TOTAL_W-1:0]  o_orbit_total,
    output logic                         o_degree_overflow,
    output logic                         o_last_of_run,
    output logic                         o_adj_we,
    output logic [AAW-1:0]               o_adj_waddr,
    output logic [goc_pkg::ID_W-1:0]     o_adj_wdata,
    output logic [AAW-1:0]               o_adj_raddr,
    input  logic [goc_pkg::ID_W-1:0]     i_adj_rdata,
    output logic                         o_deg_we,
    output logic [VAW-1:0]               o_deg_waddr,
    output logic [DW-1:0]                o_deg_wdata,
    output logic [VAW-1:0]               o_deg_raddr,
    input  logic [DW-1:0]                i_deg_rdata
);

    localparam int NS = 37;

    typedef enum logic [NS-1:0] {
        S_IDLE  = NS'(1) << 0,  S_CLR   = NS'(1) << 1,  S_APW   = NS'(1) << 2,
        S_QDW   = NS'(1) << 3,  S_IL    = NS'(1) << 4,  S_IAW   = NS'(1) << 5,
        S_INBW  = NS'(1) << 6,  S_JL    = NS'(1) << 7,  S_JSW   = NS'(1) << 8,
        S_JNCW  = NS'(1) << 9,  S_K4    = NS'(1) << 10, S_K4W   = NS'(1) << 11,
        S_K5    = NS'(1) << 12, S_K5W   = NS'(1) << 13, S_K6    = NS'(1) << 14,
        S_K6W   = NS'(1) << 15, S_M9    = NS'(1) << 16, S_M9W   = NS'(1) << 17,
        S_PL    = NS'(1) << 18, S_PBW   = NS'(1) << 19, S_PNOW  = NS'(1) << 20,
        S_TS    = NS'(1) << 21, S_TSW   = NS'(1) << 22, S_K7    = NS'(1) << 23,
        S_K7W   = NS'(1) << 24, S_MG    = NS'(1) << 25, S_MGBW  = NS'(1) << 26,
        S_MGOW  = NS'(1) << 27, S_HS    = NS'(1) << 28, S_HSW   = NS'(1) << 29,
        S_K11   = NS'(1) << 30, S_K11W  = NS'(1) << 31, S_K10A  = NS'(1) << 32,
        S_K10AW = NS'(1) << 33, S_K10B  = NS'(1) << 34, S_K10BW = NS'(1) << 35,
        S_OUT   = NS'(1) << 36
    } t_state;

    typedef logic [goc_pkg::ID_W-1:0] t_id;
    typedef logic [DW-1:0]            t_idx;

    t_state r_state, n_state;
    logic [VAW-1:0] r_ci, n_ci;
    logic r_ovf, n_ovf;
    t_id  r_v, n_v, r_nid, n_nid, r_a, n_a, r_s, n_s, r_o, n_o, r_b, n_b;
    t_id  r_bx, n_bx, r_f, n_f;
    t_idx r_na, n_na, r_nb, n_nb, r_nc, n_nc, r_no, n_no;
    t_idx r_i, n_i, r_j, n_j, r_k, n_k, r_m, n_m, r_x, n_x, r_y, n_y;
    logic r_tri, n_tri;
    logic [goc_pkg::ORBIT_W-1:0] r_oidx, n_oidx;
    logic [COUNT_WIDTH-1:0] r_cnt [goc_pkg::ORBITS];
    logic [goc_pkg::ORBITS-1:0] bump;
    logic cnt_clr, cnt_ld0;
    logic [COUNT_WIDTH+goc_pkg::TOTAL_W-1:0] total_ext;

    function automatic logic [VAW-1:0] vaddr(input t_id id);
        logic [VAW+goc_pkg::ID_W-1:0] t;
        t = {{VAW{1'b0}}, id};
        return t[VAW-1:0];
    endfunction

    function automatic logic inr(input t_id id);
        return 32'(id) < 32'(MAX_VERTICES);
    endfunction

    function automatic logic [AAW-1:0] aaddr(input t_id vert, input t_idx idx);
        return {vaddr(vert), idx[SW-1:0]};
    endfunction

    always_comb begin
        n_state = r_state;
        n_ci = r_ci;   n_ovf = r_ovf;  n_v = r_v;   n_nid = r_nid;
        n_a = r_a;     n_s = r_s;      n_o = r_o;   n_b = r_b;
        n_bx = r_bx;   n_f = r_f;      n_na = r_na; n_nb = r_nb;
        n_nc = r_nc;   n_no = r_no;    n_i = r_i;   n_j = r_j;
        n_k = r_k;     n_m = r_m;      n_x = r_x;   n_y = r_y;
        n_tri = r_tri; n_oidx = r_oidx;
        bump = '0;
        cnt_clr = 1'b0;
        cnt_ld0 = 1'b0;
        o_adj_we = 1'b0;
        o_adj_waddr = aaddr(r_v, i_deg_rdata);
        o_adj_wdata = r_nid;
        o_adj_raddr = '0;
        o_deg_we = 1'b0;
        o_deg_waddr = vaddr(r_v);
        o_deg_wdata = i_deg_rdata + DW'(1);
        o_deg_raddr = vaddr(i_vertex_id);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_v = i_vertex_id;
                    n_nid = i_neighbor_id;
                    case (goc_pkg::t_opcode'(i_opcode))
                        goc_pkg::OP_APPEND: n_state = S_APW;
                        goc_pkg::OP_CLEAR: begin
                            n_ci = '0;
                            n_ovf = 1'b0;
                            n_state = S_CLR;
                        end
                        goc_pkg::OP_COUNT: begin
                            cnt_clr = 1'b1;
                            n_state = S_QDW;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_deg_we = 1'b1;
                o_deg_waddr = r_ci;
                o_deg_wdata = '0;
                n_ci = r_ci + VAW'(1);
                if (r_ci == VAW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_APW: begin
                if (inr(r_v)) begin
                    if (i_deg_rdata >= DW'(MAX_DEGREE)) begin
                        n_ovf = 1'b1;
                    end else begin
                        o_adj_we = 1'b1;
                        o_deg_we = 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            S_QDW: begin
                n_na = inr(r_v) ? i_deg_rdata : '0;
                cnt_ld0 = 1'b1;
                n_i = '0;
                n_state = S_IL;
            end
            S_IL: begin
                if (r_i == r_na) begin
                    n_oidx = '0;
                    n_state = S_OUT;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_i);
                    n_state = S_IAW;
                end
            end
            S_IAW: begin
                n_a = i_adj_rdata;
                o_deg_raddr = vaddr(i_adj_rdata);
                n_state = S_INBW;
            end
            S_INBW: begin
                n_nb = inr(r_a) ? i_deg_rdata : '0;
                n_j = '0;
                n_state = S_JL;
            end
            S_JL: begin
                if (r_j == r_nb) begin
                    n_j = r_i + DW'(1);
                    n_state = S_PL;
                end else begin
                    o_adj_raddr = aaddr(r_a, r_j);
                    n_state = S_JSW;
                end
            end
            S_JSW: begin
                n_s = i_adj_rdata;
                if (i_adj_rdata == r_v) begin
                    n_j = r_j + DW'(1);
                    n_state = S_JL;
                end else begin
                    bump[1] = 1'b1;
                    o_deg_raddr = vaddr(i_adj_rdata);
                    n_state = S_JNCW;
                end
            end
            S_JNCW: begin
                n_nc = inr(r_s) ? i_deg_rdata : '0;
                n_k = '0;
                n_state = S_K4;
            end
            S_K4: begin
                if (r_k == r_nc) begin
                    n_k = '0;
                    n_state = S_K5;
                end else begin
                    o_adj_raddr = aaddr(r_s, r_k);
                    n_state = S_K4W;
                end
            end
            S_K4W: begin
                bump[4] = i_adj_rdata != r_v && i_adj_rdata != r_a && i_adj_rdata != r_s;
                n_k = r_k + DW'(1);
                n_state = S_K4;
            end
            S_K5: begin
                if (r_k == r_na) begin
                    n_k = r_j + DW'(1);
                    n_state = S_K6;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_k);
                    n_state = S_K5W;
                end
            end
            S_K5W: begin
                bump[5] = i_adj_rdata != r_a && i_adj_rdata != r_s;
                n_k = r_k + DW'(1);
                n_state = S_K5;
            end
            S_K6: begin
                if (r_k == r_nb) begin
                    n_j = r_j + DW'(1);
                    n_state = S_JL;
                end else begin
                    o_adj_raddr = aaddr(r_a, r_k);
                    n_state = S_K6W;
                end
            end
            S_K6W: begin
                n_o = i_adj_rdata;
                if (i_adj_rdata != r_v && i_adj_rdata != r_s) begin
                    bump[6] = 1'b1;
                    n_m = '0;
                    n_state = S_M9;
                end else begin
                    n_k = r_k + DW'(1);
                    n_state = S_K6;
                end
            end
            S_M9: begin
                if (r_m == r_nc) begin
                    n_k = r_k + DW'(1);
                    n_state = S_K6;
                end else begin
                    o_adj_raddr = aaddr(r_s, r_m);
                    n_state = S_M9W;
                end
            end
            S_M9W: begin
                if (i_adj_rdata == r_o) begin
                    bump[9] = 1'b1;
                    n_k = r_k + DW'(1);
                    n_state = S_K6;
                end else begin
                    n_m = r_m + DW'(1);
                    n_state = S_M9;
                end
            end
            S_PL: begin
                if (r_j == r_na) begin
                    n_i = r_i + DW'(1);
                    n_state = S_IL;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_j);
                    n_state = S_PBW;
                end
            end
            S_PBW: begin
                n_b = i_adj_rdata;
                o_deg_raddr = vaddr(i_adj_rdata);
                n_state = S_PNOW;
            end
            S_PNOW: begin
                n_no = inr(r_b) ? i_deg_rdata : '0;
                bump[2] = 1'b1;
                n_tri = 1'b0;
                n_k = '0;
                n_state = S_TS;
            end
            S_TS: begin
                if (r_k == r_nb) begin
                    n_k = '0;
                    n_state = S_K7;
                end else begin
                    o_adj_raddr = aaddr(r_a, r_k);
                    n_state = S_TSW;
                end
            end
            S_TSW: begin
                if (i_adj_rdata == r_b) begin
                    n_tri = 1'b1;
                    n_k = '0;
                    n_state = S_K7;
                end else begin
                    n_k = r_k + DW'(1);
                    n_state = S_TS;
                end
            end
            S_K7: begin
                if (r_k == r_na) begin
                    n_x = '0;
                    n_y = '0;
                    n_state = S_MG;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_k);
                    n_state = S_K7W;
                end
            end
            S_K7W: begin
                bump[7] = i_adj_rdata < r_a && i_adj_rdata < r_b;
                n_k = r_k + DW'(1);
                n_state = S_K7;
            end
            S_MG: begin
                if (r_x == r_nb || r_y == r_no) begin
                    if (r_tri) begin
                        bump[3] = 1'b1;
                        n_k = '0;
                        n_state = S_K11;
                    end else begin
                        n_j = r_j + DW'(1);
                        n_state = S_PL;
                    end
                end else begin
                    o_adj_raddr = aaddr(r_a, r_x);
                    n_state = S_MGBW;
                end
            end
            S_MGBW: begin
                n_bx = i_adj_rdata;
                o_adj_raddr = aaddr(r_b, r_y);
                n_state = S_MGOW;
            end
            S_MGOW: begin
                n_state = S_MG;
                if (r_bx < i_adj_rdata) begin
                    n_x = r_x + DW'(1);
                end else if (i_adj_rdata < r_bx) begin
                    n_y = r_y + DW'(1);
                end else begin
                    n_x = r_x + DW'(1);
                    n_y = r_y + DW'(1);
                    n_f = r_bx;
                    if (r_bx != r_v && r_bx != r_a && r_bx != r_b) begin
                        bump[8] = 1'b1;
                        bump[12] = r_tri;
                        if (r_a < r_b) begin
                            n_m = '0;
                            n_state = S_HS;
                        end
                    end
                end
            end
            S_HS: begin
                if (r_m == r_na) begin
                    n_state = S_MG;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_m);
                    n_state = S_HSW;
                end
            end
            S_HSW: begin
                if (i_adj_rdata == r_f) begin
                    bump[13] = 1'b1;
                    bump[14] = r_tri && r_b < r_f;
                    n_state = S_MG;
                end else begin
                    n_m = r_m + DW'(1);
                    n_state = S_HS;
                end
            end
            S_K11: begin
                if (r_k == r_na) begin
                    n_k = '0;
                    n_state = S_K10A;
                end else begin
                    o_adj_raddr = aaddr(r_v, r_k);
                    n_state = S_K11W;
                end
            end
            S_K11W: begin
                bump[11] = i_adj_rdata != r_a && i_adj_rdata != r_b;
                n_k = r_k + DW'(1);
                n_state = S_K11;
            end
            S_K10A: begin
                if (r_k == r_nb) begin
                    n_k = '0;
                    n_state = S_K10B;
                end else begin
                    o_adj_raddr = aaddr(r_a, r_k);
                    n_state = S_K10AW;
                end
            end
            S_K10AW: begin
                bump[10] = i_adj_rdata != r_v && i_adj_rdata != r_b;
                n_k = r_k + DW'(1);
                n_state = S_K10A;
            end
            S_K10B: begin
                if (r_k == r_no) begin
                    n_j = r_j + DW'(1);
                    n_state = S_PL;
                end else begin
                    o_adj_raddr = aaddr(r_b, r_k);
                    n_state = S_K10BW;
                end
            end
            S_K10BW: begin
                bump[10] = i_adj_rdata != r_v && i_adj_rdata != r_a;
                n_k = r_k + DW'(1);
                n_state = S_K10B;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_oidx == goc_pkg::LAST_ORBIT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + goc_pkg::ORBIT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ci <= '0;
            r_ovf <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            r_ci <= n_ci;
            r_ovf <= n_ovf;
            r_oidx <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;   r_nid <= n_nid; r_a <= n_a;   r_s <= n_s;
        r_o <= n_o;   r_b <= n_b;     r_bx <= n_bx; r_f <= n_f;
        r_na <= n_na; r_nb <= n_nb;   r_nc <= n_nc; r_no <= n_no;
        r_i <= n_i;   r_j <= n_j;     r_k <= n_k;   r_m <= n_m;
        r_x <= n_x;   r_y <= n_y;     r_tri <= n_tri;
    end

    always_ff @(posedge i_clk) begin
        for (int q = 0; q < goc_pkg::ORBITS; q++) begin
            if (!i_rst_n || cnt_clr) begin
                r_cnt[q] <= '0;
            end else if (q == 0 && cnt_ld0) begin
                r_cnt[q] <= COUNT_WIDTH'(n_na);
            end else if (bump[q] && r_cnt[q] != '1) begin
                r_cnt[q] <= r_cnt[q] + COUNT_WIDTH'(1);
            end
        end
    end

    assign total_ext = {{goc_pkg::TOTAL_W{1'b0}}, r_cnt[r_oidx]};

    assign o_stall           = r_state != S_IDLE;
    assign o_valid           = r_state == S_OUT;
    assign o_orbit_index     = r_oidx;
    assign o_orbit_total     = total_ext[goc_pkg::TOTAL_W-1:0];
    assign o_degree_overflow = r_ovf;
    assign o_last_of_run     = r_oidx == goc_pkg::LAST_ORBIT;

endmodule

/* rtl/graphlet_orbit_counter_top.sv */
// Top level of the graphlet orbit counter: adjacency RAM, degree RAM and walker.
// Append reads a degree, then writes the list entry and the new degree. Clear zeroes every
// degree entry. A query issues its memory reads one at a time, of order deg^4 of them, then 15 transfers.
// One item is in work at a time; input is stalled until its last result transfers.
// Synchronous reset starts a pass that zeroes the degree RAM; no item is taken during it.
module graphlet_orbit_counter_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [goc_pkg::OP_W-1:0]     i_opcode,
    input  logic [goc_pkg::ID_W-1:0]     i_vertex_id,
    input  logic [goc_pkg::ID_W-1:0]     i_neighbor_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [goc_pkg::ORBIT_W-1:0]  o_orbit_index,
    output logic [goc_pkg::TOTAL_W-1:0]  o_orbit_total,
    output logic                         o_degree_overflow,
    output logic                         o_last_of_run
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int SW  = $clog2(MAX_DEGREE);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int AAW = VAW + SW;

    logic                    adj_we;
    logic [AAW-1:0]          adj_waddr, adj_raddr;
    logic [goc_pkg::ID_W-1:0] adj_wdata, adj_rdata;
    logic                    deg_we;
    logic [VAW-1:0]          deg_waddr, deg_raddr;
    logic [DW-1:0]           deg_wdata, deg_rdata;

    goc_ram #(
        .WIDTH (goc_pkg::ID_W),
        .DEPTH (MAX_VERTICES * (2 ** SW))
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    goc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    goc_walker #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_walker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_vertex_id       (i_vertex_id),
        .i_neighbor_id     (i_neighbor_id),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_orbit_index     (o_orbit_index),
        .o_orbit_total     (o_orbit_total),
        .o_degree_overflow (o_degree_overflow),
        .o_last_of_run     (o_last_of_run),
        .o_adj_we          (adj_we),
        .o_adj_waddr       (adj_waddr),
        .o_adj_wdata       (adj_wdata),
        .o_adj_raddr       (adj_raddr),
        .i_adj_rdata       (adj_rdata),
        .o_deg_we          (deg_we),
        .o_deg_waddr       (deg_waddr),
        .o_deg_wdata       (deg_wdata),
        .o_deg_raddr       (deg_raddr),
        .i_deg_rdata       (deg_rdata)
    );

endmodule

/* dv/graphlet_orbit_counter_top_tb.sv */
// Self-checking testbench of the graphlet orbit counter: table-driven and random graphs.
module graphlet_orbit_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = goc_pkg::OP_W;
    localparam int ID_W    = goc_pkg::ID_W;
    localparam int ORBIT_W = goc_pkg::ORBIT_W;
    localparam int TOTAL_W = goc_pkg::TOTAL_W;
    localparam int ORBITS  = goc_pkg::ORBITS;

    localparam int NV = 1024;
    localparam int ND = 32;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int IDLE_LIMIT = 700000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct {
        logic [ORBIT_W-1:0] idx;
        logic [TOTAL_W-1:0] total;
        logic               ovf;
        logic               last;
    } t_orbit_result;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] vid;
        logic [ID_W-1:0] nid;
        bit              typed;
        int              exp_deg;
        bit              exp_ovf;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_W-1:0]      i_opcode;
    logic [ID_W-1:0]      i_vertex_id;
    logic [ID_W-1:0]      i_neighbor_id;
    logic                 o_valid;
    logic                 i_stall;
    logic [ORBIT_W-1:0]   o_orbit_index;
    logic [TOTAL_W-1:0]   o_orbit_total;
    logic                 o_degree_overflow;
    logic                 o_last_of_run;

    graphlet_orbit_counter_top dut (.*);

    // predictor state
    logic [ID_W-1:0]   nbr_mem [NV][ND];
    int                nbr_cnt [NV];
    bit                ovf_flag;
    t_orbit_result     orbit_q [$];
    int                fail_cnt;
    int                xfer_cnt;
    int                idle_cycles;
    bit                burst_in;
    bit                burst_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit listed(input int w, input int x);
        for (int i = 0; i < nbr_cnt[w]; i++)
            if (nbr_mem[w][i] == x) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void bump(ref logic [TOTAL_W-1:0] c);
        if (c != TOTAL_MAX) c = c + 1'b1;
    endfunction

    function automatic void count_orbits(input int v, ref logic [TOTAL_W-1:0] c [ORBITS]);
        int na, nb, nc, no, a, b, s, t, o, f, x, y;
        bit has_tri;
        foreach (c[k]) c[k] = '0;
        na = nbr_cnt[v];
        c[0] = na;
        for (int i = 0; i < na; i++) begin
            a = nbr_mem[v][i];
            nb = nbr_cnt[a];
            for (int j = 0; j < nb; j++) begin
                s = nbr_mem[a][j];
                if (s == v) continue;
                bump(c[1]);
                nc = nbr_cnt[s];
                for (int k = 0; k < nc; k++) begin
                    t = nbr_mem[s][k];
                    if (t != v && t != a && t != s) bump(c[4]);
                end
                for (int k = 0; k < na; k++)
                    if (nbr_mem[v][k] != a && nbr_mem[v][k] != s) bump(c[5]);
                for (int k = j + 1; k < nb; k++) begin
                    o = nbr_mem[a][k];
                    if (o != v && o != s) begin
                        bump(c[6]);
                        if (listed(s, o)) bump(c[9]);
                    end
                end
            end
            for (int j = i + 1; j < na; j++) begin
                b = nbr_mem[v][j];
                no = nbr_cnt[b];
                has_tri = listed(a, b);
                bump(c[2]);
                for (int k = 0; k < na; k++)
                    if (nbr_mem[v][k] < a && nbr_mem[v][k] < b) bump(c[7]);
                x = 0;
                y = 0;
                while (x < nb && y < no) begin
                    if (nbr_mem[a][x] < nbr_mem[b][y]) begin
                        x++;
                    end else if (nbr_mem[b][y] < nbr_mem[a][x]) begin
                        y++;
                    end else begin
                        f = nbr_mem[a][x];
                        x++;
                        y++;
                        if (f != v && f != a && f != b) begin
                            bump(c[8]);
                            if (a < b && listed(v, f)) bump(c[13]);
                            if (has_tri) begin
                                bump(c[12]);
                                if (a < b && b < f && listed(v, f)) bump(c[14]);
                            end
                        end
                    end
                end
                if (has_tri) begin
                    bump(c[3]);
                    for (int k = 0; k < na; k++)
                        if (nbr_mem[v][k] != a && nbr_mem[v][k] != b) bump(c[11]);
                    for (int k = 0; k < nb; k++)
                        if (nbr_mem[a][k] != v && nbr_mem[a][k] != b) bump(c[10]);
                    for (int k = 0; k < no; k++)
                        if (nbr_mem[b][k] != v && nbr_mem[b][k] != a) bump(c[10]);
                end
            end
        end
    endfunction

    function automatic void apply_item(input t_stim_row r);
        logic [TOTAL_W-1:0] c [ORBITS];
        t_orbit_result res;
        case (r.op)
            goc_pkg::OP_APPEND: begin
                if (nbr_cnt[r.vid] >= ND) begin
                    ovf_flag = 1'b1;
                end else begin
                    nbr_mem[r.vid][nbr_cnt[r.vid]] = r.nid;
                    nbr_cnt[r.vid]++;
                end
            end
            goc_pkg::OP_CLEAR: begin
                foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
                ovf_flag = 1'b0;
            end
            goc_pkg::OP_COUNT: begin
                if (r.typed) begin
                    foreach (c[k]) c[k] = '0;
                    c[0] = r.exp_deg;
                end else begin
                    count_orbits(r.vid, c);
                end
                for (int k = 0; k < ORBITS; k++) begin
                    res.idx   = ORBIT_W'(k);
                    res.total = c[k];
                    res.ovf   = r.typed ? r.exp_ovf : ovf_flag;
                    res.last  = ORBIT_W'(k) == goc_pkg::LAST_ORBIT;
                    orbit_q.insert(orbit_q.size(), res);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic transfer_item(input t_stim_row r);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= r.op;
        i_vertex_id   <= r.vid;
        i_neighbor_id <= r.nid;
        do @(posedge i_clk); while (o_stall);
        apply_item(r);
    endtask

    task automatic send(input logic [OP_W-1:0] op, input int vid, input int nid);
        transfer_item('{op, ID_W'(vid), ID_W'(nid), 1'b0, 0, 1'b0});
    endtask

    // result side: random stalls, one long hold-off, field-by-field compare
    initial begin
        int n;
        t_orbit_result e;
        i_stall = 1'b1;
        xfer_cnt = 0;
        fail_cnt = 0;
        burst_out = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (xfer_cnt % 20 == 0) burst_out = ($urandom_range(0, 2) == 0);
            n = (xfer_cnt == 40) ? 400 : (burst_out ? 0 : $urandom_range(0, 4));
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            xfer_cnt++;
            if (orbit_q.size() == 0) begin
                $display("%0t unexpected result: orbit %0d total %0d", $time,
                         o_orbit_index, o_orbit_total);
                fail_cnt++;
            end else begin
                e = orbit_q.pop_front();
                if (o_orbit_index !== e.idx || o_orbit_total !== e.total
                    || o_degree_overflow !== e.ovf || o_last_of_run !== e.last) begin
                    $display("%0t mismatch: expected idx %0d total %0d ovf %0b last %0b",
                             $time, e.idx, e.total, e.ovf, e.last);
                    $display("%0t            actual idx %0d total %0d ovf %0b last %0b",
                             $time, o_orbit_index, o_orbit_total, o_degree_overflow,
                             o_last_of_run);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_stim_row dir_rows [] = '{
        '{goc_pkg::OP_COUNT,  10'd0,    10'd0,    1'b1, 0, 1'b0},
        '{OP_NONE,            10'd1023, 10'd1023, 1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd0,    10'd1023, 1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd1023, 10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd1023, 10'd0,    1'b1, 1, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd1,    10'd2,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd1,    10'd3,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd1,    10'd4,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd2,    10'd1,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd2,    10'd3,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd3,    10'd1,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd3,    10'd2,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd3,    10'd4,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd4,    10'd1,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd4,    10'd3,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd1,    10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd2,    10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd3,    10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd5,    10'd3,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd5,    10'd1,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_APPEND, 10'd5,    10'd1,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd5,    10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_CLEAR,  10'd0,    10'd0,    1'b0, 0, 1'b0},
        '{goc_pkg::OP_COUNT,  10'd1,    10'd0,    1'b1, 0, 1'b0}
    };

    initial begin
        int items, rounds, np, id, hv, qv;
        int pool [$];
        bit link [8][8];
        bit scramble;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = goc_pkg::OP_APPEND;
        i_vertex_id   = '0;
        i_neighbor_id = '0;
        burst_in      = 1'b0;
        ovf_flag      = 1'b0;
        foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) transfer_item(dir_rows[i]);

        items = dir_rows.size();
        rounds = 0;
        while (items < 140) begin
            burst_in = ($urandom_range(0, 2) == 0);
            send(goc_pkg::OP_CLEAR, $urandom, $urandom);
            items++;
            if (rounds == 2) begin
                // fill one list past its limit, then query it
                hv = $urandom_range(0, NV - 1);
                for (int j = 0; j <= ND; j++) send(goc_pkg::OP_APPEND, hv, j * 31);
                send(goc_pkg::OP_APPEND, hv, $urandom);
                send(goc_pkg::OP_COUNT, hv, $urandom);
                items += ND + 3;
            end
            pool.delete();
            np = $urandom_range(4, 7);
            while (pool.size() < np) begin
                id = $urandom_range(0, NV - 1);
                if (!(id inside {pool})) pool.insert(pool.size(), id);
            end
            pool.sort();
            for (int i = 0; i < np; i++)
                for (int j = i + 1; j < np; j++) begin
                    link[i][j] = ($urandom_range(0, 9) < 6);
                    link[j][i] = link[i][j];
                end
            scramble = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < np; i++)
                for (int j = 0; j < np; j++) begin
                    hv = scramble ? np - 1 - j : j;
                    if (hv != i && link[i][hv]) begin
                        send(goc_pkg::OP_APPEND, pool[i], pool[hv]);
                        items++;
                    end
                end
            for (int q = 0; q < 4; q++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send(OP_NONE, $urandom, $urandom);
                    send(goc_pkg::OP_APPEND, $urandom, $urandom);
                    items += 2;
                end
                qv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NV - 1)
                                                 : pool[$urandom_range(0, np - 1)];
                send(goc_pkg::OP_COUNT, qv, $urandom);
                items++;
            end
            rounds++;
        end
        i_valid <= 1'b0;

        while (orbit_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0 && orbit_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
